[sv/bsde_pkg.sv]
// ----------------------------------------------------------------------------
// bsde_pkg
// Shared types and constants of the bitmap shape draw engine: command codes,
// decoded operations, queue entry and back-end state encoding.
// ----------------------------------------------------------------------------
package bsde_pkg;

    localparam int FUNC_W     = 3;
    localparam int FIELD_W    = 6;
    localparam int ROW_BITS_W = 40;
    localparam int SQ_W       = 12;

    // command queue between front and back end (power of two depth)
    localparam int Q_DEPTH = 2;
    localparam int Q_IDX_W = 1;

    // input function codes
    localparam logic [FUNC_W-1:0] FUNC_FILL    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_LINE    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_TRI     = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CIRCLE  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_ERASE   = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_DISPLAY = 3'd5;

    // decoded operation carried through the queue
    typedef enum logic [2:0] {
        OP_FILL,
        OP_ERASE,
        OP_LINE_H,
        OP_LINE_V,
        OP_TRI,
        OP_CIRCLE,
        OP_DISPLAY
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] col;
        logic [FIELD_W-1:0] width;
        logic [FIELD_W-1:0] height;
        logic [FIELD_W-1:0] end_row;
        logic [FIELD_W-1:0] end_col;
        logic [FIELD_W-1:0] size;
        logic [FIELD_W-1:0] radius;
    } t_cmd;

    // head of the command queue as seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_queue_head;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_PIXEL,
        ST_WRITE,
        ST_EMIT
    } t_back_state;

endpackage

[sv/bsde_cmd_if.sv]
// ----------------------------------------------------------------------------
// bsde_cmd_if
// Drawing command channel: valid/ready handshake with the command fields.
// ----------------------------------------------------------------------------
interface bsde_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [5:0] row;
    logic [5:0] col;
    logic [5:0] width;
    logic [5:0] height;
    logic [5:0] end_row;
    logic [5:0] end_col;
    logic [5:0] size;
    logic [5:0] radius;

    modport source (
        output valid, func, row, col, width, height, end_row, end_col, size, radius,
        input  ready
    );
    modport sink (
        input  valid, func, row, col, width, height, end_row, end_col, size, radius,
        output ready
    );
endinterface

[sv/bsde_row_if.sv]
// ----------------------------------------------------------------------------
// bsde_row_if
// Canvas row output channel: valid/ready handshake with one row per transaction.
// ----------------------------------------------------------------------------
interface bsde_row_if;
    logic        valid;
    logic        ready;
    logic [5:0]  row_index;
    logic [39:0] row_bits;
    logic        last;

    modport source (
        output valid, row_index, row_bits, last,
        input  ready
    );
    modport sink (
        input  valid, row_index, row_bits, last,
        output ready
    );
endinterface

[sv/bsde_ram.sv]
// ----------------------------------------------------------------------------
// bsde_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsde_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 20
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/bsde_front.sv]
// ----------------------------------------------------------------------------
// bsde_front
// Command front end: accepts drawing commands, decodes them, drops those that
// draw nothing and queues the rest for the back end.
// ----------------------------------------------------------------------------
module bsde_front import bsde_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bsde_cmd_if.sink      i_cmd,
    output t_queue_head   o_head,
    input  logic          i_pop
);

    t_cmd               r_q [Q_DEPTH];
    logic [Q_IDX_W-1:0] r_wp;
    logic [Q_IDX_W-1:0] r_rp;
    logic [Q_IDX_W:0]   r_cnt;

    t_cmd w_cmd;
    logic w_keep;
    logic w_ready;
    logic w_accept;
    logic w_push;
    logic w_pop;

    // decode function code into an operation, flag commands with no effect
    always_comb begin
        w_cmd.op      = OP_FILL;
        w_cmd.row     = i_cmd.row;
        w_cmd.col     = i_cmd.col;
        w_cmd.width   = i_cmd.width;
        w_cmd.height  = i_cmd.height;
        w_cmd.end_row = i_cmd.end_row;
        w_cmd.end_col = i_cmd.end_col;
        w_cmd.size    = i_cmd.size;
        w_cmd.radius  = i_cmd.radius;
        w_keep        = 1'b0;
        unique case (i_cmd.func)
            FUNC_FILL: begin
                w_cmd.op = OP_FILL;
                w_keep   = (i_cmd.width != '0) && (i_cmd.height != '0);
            end
            FUNC_ERASE: begin
                w_cmd.op = OP_ERASE;
                w_keep   = (i_cmd.width != '0) && (i_cmd.height != '0);
            end
            FUNC_LINE: begin
                // horizontal wins when both ends share a row; diagonal draws nothing
                if (i_cmd.row == i_cmd.end_row) begin
                    w_cmd.op = OP_LINE_H;
                    w_keep   = (i_cmd.end_col >= i_cmd.col);
                end else if (i_cmd.col == i_cmd.end_col) begin
                    w_cmd.op = OP_LINE_V;
                    w_keep   = (i_cmd.end_row >= i_cmd.row);
                end else begin
                    w_keep   = 1'b0;
                end
            end
            FUNC_TRI: begin
                w_cmd.op = OP_TRI;
                w_keep   = (i_cmd.size != '0);
            end
            FUNC_CIRCLE: begin
                w_cmd.op = OP_CIRCLE;
                w_keep   = 1'b1;
            end
            FUNC_DISPLAY: begin
                w_cmd.op = OP_DISPLAY;
                w_keep   = 1'b1;
            end
            default: begin
                w_keep   = 1'b0;
            end
        endcase
    end

    // handshake and queue control
    assign w_ready     = (r_cnt != (Q_IDX_W + 1)'(Q_DEPTH));
    assign i_cmd.ready = w_ready;
    assign w_accept    = i_cmd.valid && w_ready;
    assign w_push      = w_accept && w_keep;
    assign w_pop       = i_pop && (r_cnt != '0);

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_q[r_rp];

endmodule

[sv/bsde_back.sv]
// ----------------------------------------------------------------------------
// bsde_back
// Command back end: sweeps the canvas row by row, one pixel per cycle,
// updating each row in a read-modify-write, or emits rows for display.
// ----------------------------------------------------------------------------
module bsde_back import bsde_pkg::*; #(
    parameter int CANVAS_ROWS = 20,
    parameter int CANVAS_COLS = 40
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_queue_head   i_head,
    output logic          o_pop,
    bsde_row_if.source    o_row
);

    localparam int ROW_W = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;
    localparam int COL_W = (CANVAS_COLS > 1) ? $clog2(CANVAS_COLS) : 1;

    t_back_state             r_state;
    t_back_state             n_state;
    t_cmd                    r_cmd;
    logic [ROW_W-1:0]        r_row;
    logic [COL_W-1:0]        r_col;
    logic [CANVAS_COLS-1:0]  r_line;
    logic [CANVAS_ROWS-1:0]  r_valid;
    logic [SQ_W-1:0]         r_di_sq;
    logic [SQ_W-1:0]         r_rad_sq;
    logic                    r_out_valid;
    logic [FIELD_W-1:0]      r_out_index;
    logic [ROW_BITS_W-1:0]   r_out_bits;
    logic                    r_out_last;

    logic                    w_we;
    logic [CANVAS_COLS-1:0]  w_rdata;
    logic                    w_last_row;
    logic                    w_last_col;
    logic                    w_out_free;
    logic                    w_emit;
    logic                    w_hit;

    logic [FIELD_W:0]        w_ri;
    logic [FIELD_W:0]        w_cj;
    logic [FIELD_W:0]        w_row_x;
    logic [FIELD_W:0]        w_col_x;
    logic [FIELD_W-1:0]      w_di_abs;
    logic [FIELD_W-1:0]      w_dj_abs;
    logic [SQ_W-1:0]         w_di_ext;
    logic [SQ_W-1:0]         w_dj_ext;
    logic [SQ_W-1:0]         w_rad_ext;
    logic [SQ_W-1:0]         w_dj_sq;
    logic                    w_in_r;
    logic                    w_in_c;

    // canvas row storage
    bsde_ram #(
        .WIDTH (CANVAS_COLS),
        .DEPTH (CANVAS_ROWS)
    ) u_canvas (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_row),
        .i_wdata (r_line),
        .i_raddr (r_row),
        .o_rdata (w_rdata)
    );

    assign w_last_row = (r_row == ROW_W'(CANVAS_ROWS - 1));
    assign w_last_col = (r_col == COL_W'(CANVAS_COLS - 1));
    assign w_out_free = !r_out_valid || o_row.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_state = (r_cmd.op == OP_DISPLAY) ? ST_EMIT : ST_PIXEL;
            end
            ST_PIXEL: begin
                if (w_last_col) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                n_state = w_last_row ? ST_IDLE : ST_READ;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = w_last_row ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_pop  = (r_state == ST_IDLE) && i_head.valid;
        w_we   = (r_state == ST_WRITE);
        w_emit = (r_state == ST_EMIT) && w_out_free;
    end

    // pixel coordinates and distances for the current sweep position
    always_comb begin
        w_ri      = (FIELD_W + 1)'(r_row);
        w_cj      = (FIELD_W + 1)'(r_col);
        w_row_x   = {1'b0, r_cmd.row};
        w_col_x   = {1'b0, r_cmd.col};
        w_di_abs  = (w_ri >= w_row_x) ? FIELD_W'(w_ri - w_row_x) : FIELD_W'(w_row_x - w_ri);
        w_dj_abs  = (w_cj >= w_col_x) ? FIELD_W'(w_cj - w_col_x) : FIELD_W'(w_col_x - w_cj);
        w_di_ext  = SQ_W'(w_di_abs);
        w_dj_ext  = SQ_W'(w_dj_abs);
        w_rad_ext = SQ_W'(r_cmd.radius);
        w_dj_sq   = w_dj_ext * w_dj_ext;
        w_in_r    = (w_ri >= w_row_x) && (w_ri < (w_row_x + {1'b0, r_cmd.size}));
        w_in_c    = (w_cj >= w_col_x) && (w_cj < (w_col_x + {1'b0, r_cmd.size}));
    end

    // does the current pixel belong to the shape
    always_comb begin
        w_hit = 1'b0;
        unique case (r_cmd.op)
            OP_FILL, OP_ERASE: begin
                w_hit = (w_ri >= w_row_x) && (w_ri < (w_row_x + {1'b0, r_cmd.height}))
                     && (w_cj >= w_col_x) && (w_cj < (w_col_x + {1'b0, r_cmd.width}));
            end
            OP_LINE_H: begin
                w_hit = (w_ri == w_row_x) && (w_cj >= w_col_x)
                     && (w_cj <= {1'b0, r_cmd.end_col});
            end
            OP_LINE_V: begin
                w_hit = (w_cj == w_col_x) && (w_ri >= w_row_x)
                     && (w_ri <= {1'b0, r_cmd.end_row});
            end
            OP_TRI: begin
                // left leg, bottom leg, diagonal
                w_hit = ((w_cj == w_col_x) && w_in_r)
                     || ((w_ri == (w_row_x + {1'b0, r_cmd.size} - 1'b1)) && w_in_c)
                     || (w_in_r && ((w_ri + w_col_x) == (w_cj + w_row_x)));
            end
            OP_CIRCLE: begin
                w_hit = (({1'b0, r_di_sq} + {1'b0, w_dj_sq}) <= {1'b0, r_rad_sq});
            end
            default: begin
                w_hit = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_we) begin
                r_valid[r_row] <= 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_row.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // sweep datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    r_cmd    <= i_head.cmd;
                    r_row    <= '0;
                end
            end
            ST_READ: begin
                r_di_sq <= w_di_ext * w_di_ext;
            end
            ST_LOAD: begin
                r_line <= r_valid[r_row] ? w_rdata : '0;
                r_col  <= '0;
            end
            ST_PIXEL: begin
                if (w_hit) begin
                    r_line[r_col] <= (r_cmd.op != OP_ERASE);
                end
                r_col <= r_col + 1'b1;
            end
            ST_WRITE: begin
                r_row <= r_row + 1'b1;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    r_out_index <= FIELD_W'(r_row);
                    r_out_bits  <= ROW_BITS_W'(r_line);
                    r_out_last  <= w_last_row;
                    r_row       <= r_row + 1'b1;
                end
            end
            default: begin
                r_row <= r_row;
            end
        endcase
    end

    // radius squared, taken when a command is accepted and again at each row read
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_head.valid) begin
            r_rad_sq <= SQ_W'(i_head.cmd.radius) * SQ_W'(i_head.cmd.radius);
        end else if (r_state == ST_READ) begin
            r_rad_sq <= w_rad_ext * w_rad_ext;
        end
    end

    assign o_row.valid     = r_out_valid;
    assign o_row.row_index = r_out_index;
    assign o_row.row_bits  = r_out_bits;
    assign o_row.last      = r_out_last;

endmodule

[sv/bitmap_shape_draw_engine_core.sv]
// ----------------------------------------------------------------------------
// bitmap_shape_draw_engine_core
// One-bit-per-pixel canvas taking fill, erase, line, triangle, circle and
// display commands through a queued front end and a row-sweeping back end.
// ----------------------------------------------------------------------------
// draw command: swept over all CANVAS_ROWS rows, one
//   pixel per cycle in a read-modify-write of each canvas row
// display: each row read, loaded and emitted in turn from the first row to the
//   last while the sink keeps up; two commands may queue ahead
// reset: canvas row flags cleared at once so the canvas reads blank, queue emptied
module bitmap_shape_draw_engine_core import bsde_pkg::*; #(
    parameter int CANVAS_ROWS = 20,
    parameter int CANVAS_COLS = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bsde_cmd_if.sink    i_cmd,
    bsde_row_if.source  o_row
);

    t_queue_head w_head;
    logic        w_pop;

    // decode and queue commands
    bsde_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    // execute commands over the canvas
    bsde_back #(
        .CANVAS_ROWS (CANVAS_ROWS),
        .CANVAS_COLS (CANVAS_COLS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_row   (o_row)
    );

endmodule

[sv/bsde_checker.sv]
// ----------------------------------------------------------------------------
// bsde_checker
// Port-level checks of the draw engine: output handshake and row ordering
// of display runs.
// ----------------------------------------------------------------------------
module bsde_checker #(
    parameter int CANVAS_ROWS = 20
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [5:0]  i_out_row_index,
    input logic [39:0] i_out_row_bits,
    input logic        i_out_last
);

    logic [5:0] r_exp_idx;

    // expected index of the next row transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_exp_idx <= i_out_last ? 6'd0 : (i_out_row_index + 1'b1);
        end
    end

    // stalled row holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_row_index)
            && $stable(i_out_row_bits) && $stable(i_out_last))
        else $error("output row changed while stalled");

    // rows of a display run come in order from the first
    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_row_index == r_exp_idx)
        else $error("display row out of order");

    // last flag only on the final canvas row
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_last == (i_out_row_index == 6'(CANVAS_ROWS - 1))))
        else $error("last flag on wrong row");

    // no row presented right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("row valid after reset");

endmodule

bind bitmap_shape_draw_engine_core bsde_checker #(
    .CANVAS_ROWS (CANVAS_ROWS)
) u_bsde_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_row.valid),
    .i_out_ready     (o_row.ready),
    .i_out_row_index (o_row.row_index),
    .i_out_row_bits  (o_row.row_bits),
    .i_out_last      (o_row.last)
);
